// File: hdl/tqg_pkg.sv
// Shared types, codes and constants of the transaction quota guard.
package tqg_pkg;

  localparam int CMD_W        = 3;
  localparam int ROW_SIZE_W   = 32;
  localparam int TIME_W       = 48;
  localparam int STATUS_W     = 3;
  localparam int PHASE_W      = 3;
  localparam int ROWS_W       = 32;
  localparam int BYTES_W      = 48;
  localparam int ROW_LIM_W    = 32;
  localparam int BYTE_LIM_W   = 48;
  localparam int DEADLINE_W   = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 48;

  localparam int ROW_BITS_DEF  = 32;
  localparam int BYTE_BITS_DEF = 48;
  localparam int TIME_BITS_DEF = 48;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OBSERVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FAIL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEANUP = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ARM     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLIENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ROW_LIM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BYTE_LIM = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DEADLINE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RB_ERR   = 3'd6;

  localparam logic [PHASE_W-1:0] PH_NEW       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ACTIVE    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_COMMITTED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ROLLED    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FAILED    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 2'd2;

  localparam logic [ROW_LIM_W-1:0]  ROW_LIM_RST  = 32'hFFFF_FFFF;
  localparam logic [BYTE_LIM_W-1:0] BYTE_LIM_RST = 48'hFFFF_FFFF_FFFF;
  localparam logic [DEADLINE_W-1:0] DEADLINE_RST = 32'd30000;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_OBSERVE,
    OP_FINISH,
    OP_FAIL,
    OP_CLEANUP,
    OP_ARM,
    OP_BAD
  } tqg_op_e;

  typedef struct packed {
    tqg_op_e               op;
    logic [ROW_SIZE_W-1:0] row_size;
    logic [TIME_W-1:0]     time_now;
    logic                  begin_ok;
    logic                  configure_ok;
    logic                  commit_ok;
    logic                  rollback_ok;
  } tqg_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHASE_W-1:0]  phase;
    logic                armed;
    logic [ROWS_W-1:0]   rows;
    logic [BYTES_W-1:0]  bytes;
    logic                commit_iss;
    logic                rollback_iss;
  } tqg_result_t;

  typedef struct packed {
    logic we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] wdata;
  } tqg_cfg_t;

endpackage

// File: hdl/tqg_front.sv
// Front end: accepts input words and classifies the command into an operation.
module tqg_front import tqg_pkg::*; (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [ROW_SIZE_W-1:0] row_size_i,
  input  logic [TIME_W-1:0]     time_now_i,
  input  logic                  begin_ok_i,
  input  logic                  configure_ok_i,
  input  logic                  commit_ok_i,
  input  logic                  rollback_ok_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output tqg_item_t             item_o
);

  tqg_op_e op;

  always_comb begin
    unique case (cmd_i)
      CMD_OPEN:    op = OP_OPEN;
      CMD_OBSERVE: op = OP_OBSERVE;
      CMD_FINISH:  op = OP_FINISH;
      CMD_FAIL:    op = OP_FAIL;
      CMD_CLEANUP: op = OP_CLEANUP;
      CMD_ARM:     op = OP_ARM;
      default:     op = OP_BAD;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign item_o = '{
    op:           op,
    row_size:     row_size_i,
    time_now:     time_now_i,
    begin_ok:     begin_ok_i,
    configure_ok: configure_ok_i,
    commit_ok:    commit_ok_i,
    rollback_ok:  rollback_ok_i
  };

endmodule

// File: hdl/tqg_queue.sv
// Short queue of classified words between the front end and the back end.
module tqg_queue import tqg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tqg_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output tqg_item_t item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  tqg_item_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FULL);
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/tqg_back.sv
// Back end: guard state, quota checks, configuration registers and result register.
module tqg_back import tqg_pkg::*; #(
  parameter int ROW_BITS  = ROW_BITS_DEF,
  parameter int BYTE_BITS = BYTE_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tqg_cfg_t    cfg_i,
  input  logic        q_valid_i,
  input  tqg_item_t   item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tqg_result_t res_o
);

  localparam int SUM_W = ((BYTE_BITS > ROW_SIZE_W) ? BYTE_BITS : ROW_SIZE_W) + 1;
  localparam int RCW   = (ROW_BITS > ROW_LIM_W) ? ROW_BITS : ROW_LIM_W;
  localparam int BCW   = (BYTE_BITS > BYTE_LIM_W) ? BYTE_BITS : BYTE_LIM_W;
  localparam int DCW   = (TIME_BITS > DEADLINE_W) ? TIME_BITS : DEADLINE_W;

  logic [ROW_LIM_W-1:0]  row_lim_q;
  logic [BYTE_LIM_W-1:0] byte_lim_q;
  logic [DEADLINE_W-1:0] deadline_q;

  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic                 armed_q, armed_d;
  logic [ROW_BITS-1:0]  row_q, row_d;
  logic [BYTE_BITS-1:0] byte_q, byte_d;
  logic [TIME_BITS-1:0] start_q, start_d;

  logic        out_valid_q;
  tqg_result_t res_q, res_d;

  logic                 active;
  logic [TIME_BITS-1:0] now;
  logic [SUM_W-1:0]     byte_sum;
  logic                 byte_ovf;
  logic                 row_full;
  logic [ROW_BITS-1:0]  row_inc;
  logic                 row_over;
  logic                 byte_over;
  logic                 late;
  logic [STATUS_W-1:0]  status;
  logic [STATUS_W-1:0]  rb_cause;
  logic                 rb_iss;
  logic                 commit_iss;

  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign active    = armed_q && (phase_q == PH_ACTIVE);
  assign now       = TIME_BITS'(item_i.time_now);
  assign byte_sum  = SUM_W'(byte_q) + SUM_W'(item_i.row_size);
  assign byte_ovf  = |byte_sum[SUM_W-1:BYTE_BITS];
  assign row_full  = &row_q;
  assign row_inc   = row_q + ROW_BITS'(1);
  assign row_over  = RCW'(row_inc) > RCW'(row_lim_q);
  assign byte_over = BCW'(byte_sum[BYTE_BITS-1:0]) > BCW'(byte_lim_q);
  assign late      = (now < start_q) || (DCW'(now - start_q) > DCW'(deadline_q));

  always_comb begin
    phase_d    = phase_q;
    armed_d    = armed_q;
    row_d      = row_q;
    byte_d     = byte_q;
    start_d    = start_q;
    status     = ST_OK;
    rb_cause   = ST_OK;
    rb_iss     = 1'b0;
    commit_iss = 1'b0;
    unique case (item_i.op)
      OP_ARM: begin
        phase_d = PH_NEW;
        armed_d = 1'b1;
        row_d   = '0;
        byte_d  = '0;
        start_d = '0;
      end
      OP_OPEN: begin
        if (!armed_q || phase_q != PH_NEW) begin
          status = ST_INVALID;
        end else if (!item_i.begin_ok) begin
          phase_d = PH_FAILED;
          status  = ST_CLIENT;
        end else if (!item_i.configure_ok) begin
          rb_iss   = 1'b1;
          rb_cause = ST_CLIENT;
        end else begin
          start_d = now;
          phase_d = PH_ACTIVE;
        end
      end
      OP_OBSERVE: begin
        if (!active) begin
          status = ST_INVALID;
        end else begin
          if (row_full || byte_ovf) begin
            rb_cause = ST_BYTE_LIM;
          end else begin
            row_d  = row_inc;
            byte_d = byte_sum[BYTE_BITS-1:0];
            if (row_over) begin
              rb_cause = ST_ROW_LIM;
            end else if (byte_over) begin
              rb_cause = ST_BYTE_LIM;
            end else if (late) begin
              rb_cause = ST_DEADLINE;
            end
          end
          rb_iss = (rb_cause != ST_OK);
        end
      end
      OP_FINISH: begin
        if (!active) begin
          status = ST_INVALID;
        end else begin
          commit_iss = 1'b1;
          if (item_i.commit_ok) begin
            phase_d = PH_COMMITTED;
          end else begin
            phase_d = PH_FAILED;
            status  = ST_CLIENT;
          end
        end
      end
      OP_FAIL: begin
        if (!active) begin
          status = ST_INVALID;
        end else begin
          rb_iss   = 1'b1;
          rb_cause = ST_CLIENT;
        end
      end
      OP_CLEANUP: begin
        if (armed_q) begin
          rb_iss  = active;
          armed_d = 1'b0;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
    if (rb_iss) begin
      if (item_i.rollback_ok) begin
        phase_d = PH_ROLLED;
        status  = rb_cause;
      end else begin
        phase_d = PH_FAILED;
        status  = ST_RB_ERR;
      end
    end
    res_d = '{
      status:       status,
      phase:        phase_d,
      armed:        armed_d,
      rows:         ROWS_W'(row_d),
      bytes:        BYTES_W'(byte_d),
      commit_iss:   commit_iss,
      rollback_iss: rb_iss
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_lim_q   <= ROW_LIM_RST;
      byte_lim_q  <= BYTE_LIM_RST;
      deadline_q  <= DEADLINE_RST;
      phase_q     <= PH_NEW;
      armed_q     <= 1'b1;
      row_q       <= '0;
      byte_q      <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          CFG_ROW_LIM:  row_lim_q  <= cfg_i.wdata[ROW_LIM_W-1:0];
          CFG_BYTE_LIM: byte_lim_q <= cfg_i.wdata[BYTE_LIM_W-1:0];
          CFG_DEADLINE: deadline_q <= cfg_i.wdata[DEADLINE_W-1:0];
          default: ;
        endcase
      end
      if (pop_o) begin
        phase_q     <= phase_d;
        armed_q     <= armed_d;
        row_q       <= row_d;
        byte_q      <= byte_d;
        start_q     <= start_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: hdl/transaction_quota_guard.sv
// Top level of the transaction quota guard: front end, word queue and back end.
//
//   Channel  Direction  Handshake                Carries
//   in       input      in_valid_i / in_stall_o    command word with partner outcomes
//   out      output     out_valid_o / out_stall_i  status, phase, counters, strobes
//   cfg      input      cfg_we_i                   row limit, byte limit, deadline
//
// One word is accepted per cycle while not stalled; its single result is registered after the queue.
// The back end updates the guard state and registers the result in the same cycle.
// A two-word queue sits between the front end and the back end, so input is stalled only
// while the queue is full, which happens only after the output was held by out_stall_i.
// Reset is asynchronous and active low; it arms the guard and loads the default quotas.
module transaction_quota_guard import tqg_pkg::*; #(
  parameter int ROW_BITS  = ROW_BITS_DEF,
  parameter int BYTE_BITS = BYTE_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [ROW_SIZE_W-1:0] row_size_i,
  input  logic [TIME_W-1:0]     time_now_i,
  input  logic                  begin_ok_i,
  input  logic                  configure_ok_i,
  input  logic                  commit_ok_i,
  input  logic                  rollback_ok_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [PHASE_W-1:0]    phase_o,
  output logic                  armed_flag_o,
  output logic [ROWS_W-1:0]     rows_seen_o,
  output logic [BYTES_W-1:0]    bytes_seen_o,
  output logic                  commit_issued_o,
  output logic                  rollback_issued_o
);

  tqg_item_t   push_item;
  tqg_item_t   pop_item;
  tqg_result_t res;
  tqg_cfg_t    cfg;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, wdata: cfg_wdata_i};

  tqg_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .row_size_i     (row_size_i),
    .time_now_i     (time_now_i),
    .begin_ok_i     (begin_ok_i),
    .configure_ok_i (configure_ok_i),
    .commit_ok_i    (commit_ok_i),
    .rollback_ok_i  (rollback_ok_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  tqg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  tqg_back #(
    .ROW_BITS  (ROW_BITS),
    .BYTE_BITS (BYTE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o          = res.status;
  assign phase_o           = res.phase;
  assign armed_flag_o      = res.armed;
  assign rows_seen_o       = res.rows;
  assign bytes_seen_o      = res.bytes;
  assign commit_issued_o   = res.commit_iss;
  assign rollback_issued_o = res.rollback_iss;

  // The queue fills only while the back end is held, so a full queue means a pending result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_commit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_issued_o) |->
      (!rollback_issued_o && (phase_o == PH_COMMITTED || phase_o == PH_FAILED)))
    else $error("commit strobe with inconsistent phase");

  a_rollback_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rollback_issued_o) |->
      (phase_o == PH_ROLLED || phase_o == PH_FAILED))
    else $error("rollback strobe with inconsistent phase");

endmodule

// File: dv/tb_transaction_quota_guard.sv
// Self-checking testbench of transaction_quota_guard: directed table, random sessions, checks.
module tb_transaction_quota_guard import tqg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int IDLE_MAX     = 14;
  localparam int RANDOM_WORDS = 600;
  localparam int PHASE_WORDS  = 100;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [ROW_SIZE_W-1:0] row_size;
    logic [TIME_W-1:0]     time_now;
    logic                  begin_ok;
    logic                  configure_ok;
    logic                  commit_ok;
    logic                  rollback_ok;
  } guard_word_t;

  typedef struct {
    bit                     is_cfg;
    guard_word_t            w;
    bit                     typed;
    tqg_result_t            res;
    logic [ROW_LIM_W-1:0]   lim_rows;
    logic [BYTE_LIM_W-1:0]  lim_bytes;
    logic [DEADLINE_W-1:0]  lim_deadline;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i;
  logic [ROW_SIZE_W-1:0] row_size_i;
  logic [TIME_W-1:0]     time_now_i;
  logic                  begin_ok_i;
  logic                  configure_ok_i;
  logic                  commit_ok_i;
  logic                  rollback_ok_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [PHASE_W-1:0]    phase_o;
  logic                  armed_flag_o;
  logic [ROWS_W-1:0]     rows_seen_o;
  logic [BYTES_W-1:0]    bytes_seen_o;
  logic                  commit_issued_o;
  logic                  rollback_issued_o;

  transaction_quota_guard dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .row_size_i        (row_size_i),
    .time_now_i        (time_now_i),
    .begin_ok_i        (begin_ok_i),
    .configure_ok_i    (configure_ok_i),
    .commit_ok_i       (commit_ok_i),
    .rollback_ok_i     (rollback_ok_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .phase_o           (phase_o),
    .armed_flag_o      (armed_flag_o),
    .rows_seen_o       (rows_seen_o),
    .bytes_seen_o      (bytes_seen_o),
    .commit_issued_o   (commit_issued_o),
    .rollback_issued_o (rollback_issued_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard state as the testbench expects it.
  logic [PHASE_W-1:0]    g_phase;
  logic                  g_armed;
  logic [ROWS_W-1:0]     g_rows;
  logic [BYTES_W-1:0]    g_bytes;
  logic [TIME_W-1:0]     g_start;
  logic [ROW_LIM_W-1:0]  g_row_lim;
  logic [BYTE_LIM_W-1:0] g_byte_lim;
  logic [DEADLINE_W-1:0] g_deadline;

  tqg_result_t pending_results[$];
  plan_row_t   plan[$];
  int fail_count    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int src_idle_max  = IDLE_MAX;
  int sink_idle_max = IDLE_MAX;

  task automatic flag_error(input string msg);
    if (fail_count < MAX_REPORTS) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [TIME_W-1:0] random48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  function automatic logic [STATUS_W-1:0] settle_rollback(input logic [STATUS_W-1:0] cause,
                                                          input logic ok);
    if (ok) begin
      g_phase = PH_ROLLED;
      return cause;
    end
    g_phase = PH_FAILED;
    return ST_RB_ERR;
  endfunction

  function automatic tqg_result_t advance_guard(input guard_word_t w);
    tqg_result_t r;
    logic active;
    logic [BYTES_W:0] sum;
    r = '0;
    active = g_armed && (g_phase == PH_ACTIVE);
    sum = {1'b0, g_bytes} + (BYTES_W+1)'(w.row_size);
    case (w.cmd)
      CMD_ARM: begin
        g_phase = PH_NEW;
        g_armed = 1'b1;
        g_rows  = '0;
        g_bytes = '0;
        g_start = '0;
      end
      CMD_OPEN: begin
        if (!g_armed || g_phase != PH_NEW) begin
          r.status = ST_INVALID;
        end else if (!w.begin_ok) begin
          g_phase  = PH_FAILED;
          r.status = ST_CLIENT;
        end else if (!w.configure_ok) begin
          r.rollback_iss = 1'b1;
          r.status = settle_rollback(ST_CLIENT, w.rollback_ok);
        end else begin
          g_start = w.time_now;
          g_phase = PH_ACTIVE;
        end
      end
      CMD_OBSERVE: begin
        if (!active) begin
          r.status = ST_INVALID;
        end else if (&g_rows || sum[BYTES_W]) begin
          r.status = ST_BYTE_LIM;
        end else begin
          g_rows  = g_rows + ROWS_W'(1);
          g_bytes = sum[BYTES_W-1:0];
          if (g_rows > g_row_lim) r.status = ST_ROW_LIM;
          else if (g_bytes > g_byte_lim) r.status = ST_BYTE_LIM;
          else if ((w.time_now < g_start) ||
                   (w.time_now - g_start > TIME_W'(g_deadline))) r.status = ST_DEADLINE;
        end
        if (active && r.status != ST_OK) begin
          r.rollback_iss = 1'b1;
          r.status = settle_rollback(r.status, w.rollback_ok);
        end
      end
      CMD_FINISH: begin
        if (!active) begin
          r.status = ST_INVALID;
        end else begin
          r.commit_iss = 1'b1;
          if (w.commit_ok) begin
            g_phase = PH_COMMITTED;
          end else begin
            g_phase  = PH_FAILED;
            r.status = ST_CLIENT;
          end
        end
      end
      CMD_FAIL: begin
        if (!active) begin
          r.status = ST_INVALID;
        end else begin
          r.rollback_iss = 1'b1;
          r.status = settle_rollback(ST_CLIENT, w.rollback_ok);
        end
      end
      CMD_CLEANUP: begin
        if (g_armed) begin
          if (active) begin
            r.rollback_iss = 1'b1;
            r.status = settle_rollback(ST_OK, w.rollback_ok);
          end
          g_armed = 1'b0;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.phase = g_phase;
    r.armed = g_armed;
    r.rows  = g_rows;
    r.bytes = g_bytes;
    return r;
  endfunction

  function automatic guard_word_t make_word(input logic [CMD_W-1:0] cmd,
                                            input logic [TIME_W-1:0] t);
    guard_word_t w;
    w.cmd          = cmd;
    w.row_size     = $urandom;
    w.time_now     = t;
    w.begin_ok     = 1'($urandom_range(0, 1));
    w.configure_ok = 1'($urandom_range(0, 1));
    w.commit_ok    = ($urandom_range(0, 3) != 0);
    w.rollback_ok  = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  function automatic void plan_word(input logic [CMD_W-1:0] cmd,
                                    input logic [ROW_SIZE_W-1:0] size,
                                    input logic [TIME_W-1:0] t, input logic [3:0] oks);
    plan_row_t p;
    p = '{default: '0};
    p.w.cmd = cmd;
    p.w.row_size = size;
    p.w.time_now = t;
    {p.w.begin_ok, p.w.configure_ok, p.w.commit_ok, p.w.rollback_ok} = oks;
    plan.push_back(p);
  endfunction

  function automatic void plan_typed(input logic [CMD_W-1:0] cmd, input logic [3:0] oks,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [PHASE_W-1:0] ph, input logic arm,
                                     input logic ci, input logic ri);
    plan_word(cmd, $urandom, random48(), oks);
    plan[$].typed = 1'b1;
    plan[$].res = '{status: st, phase: ph, armed: arm, rows: '0, bytes: '0,
                    commit_iss: ci, rollback_iss: ri};
  endfunction

  function automatic void plan_limits(input logic [ROW_LIM_W-1:0] r,
                                      input logic [BYTE_LIM_W-1:0] b,
                                      input logic [DEADLINE_W-1:0] d);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.lim_rows = r;
    p.lim_bytes = b;
    p.lim_deadline = d;
    plan.push_back(p);
  endfunction

  task automatic send_word(input guard_word_t w, input bit typed, input tqg_result_t want);
    int gap;
    tqg_result_t predicted;
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= w.cmd;
    row_size_i     <= w.row_size;
    time_now_i     <= w.time_now;
    begin_ok_i     <= w.begin_ok;
    configure_ok_i <= w.configure_ok;
    commit_ok_i    <= w.commit_ok;
    rollback_ok_i  <= w.rollback_ok;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_guard(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic settle_guard();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [ROW_LIM_W-1:0] r,
                                input logic [BYTE_LIM_W-1:0] b,
                                input logic [DEADLINE_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROW_LIM;
    cfg_wdata_i <= {16'($urandom), r};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BYTE_LIM;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DEADLINE;
    cfg_wdata_i <= {16'($urandom), d};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= random48();
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    g_row_lim   = r;
    g_byte_lim  = b;
    g_deadline  = d;
  endtask

  initial begin : result_sink
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      hold = $urandom_range(0, sink_idle_max);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    tqg_result_t got;
    tqg_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, phase_o, armed_flag_o, rows_seen_o, bytes_seen_o,
              commit_issued_o, rollback_issued_o};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("word result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          flag_error($sformatf("result %0d status %0d, expected %0d",
                               results_seen, got.status, want.status));
        if (got.phase !== want.phase)
          flag_error($sformatf("result %0d phase %0d, expected %0d",
                               results_seen, got.phase, want.phase));
        if (got.armed !== want.armed)
          flag_error($sformatf("result %0d armed %0b, expected %0b",
                               results_seen, got.armed, want.armed));
        if (got.rows !== want.rows)
          flag_error($sformatf("result %0d rows %0h, expected %0h",
                               results_seen, got.rows, want.rows));
        if (got.bytes !== want.bytes)
          flag_error($sformatf("result %0d bytes %0h, expected %0h",
                               results_seen, got.bytes, want.bytes));
        if (got.commit_iss !== want.commit_iss)
          flag_error($sformatf("result %0d commit strobe %0b, expected %0b",
                               results_seen, got.commit_iss, want.commit_iss));
        if (got.rollback_iss !== want.rollback_iss)
          flag_error($sformatf("result %0d rollback strobe %0b, expected %0b",
                               results_seen, got.rollback_iss, want.rollback_iss));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("transaction_quota_guard: mismatch");
    $finish;
  end

  initial begin : stimulus
    guard_word_t w;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] t0;
    logic [ROW_LIM_W-1:0] lim_r;
    logic [BYTE_LIM_W-1:0] lim_b;
    logic [DEADLINE_W-1:0] lim_d;
    int phase_no;
    int phase_base;
    int random_base;
    int wait_cycles;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_ROW_LIM;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CMD_ARM;
    row_size_i     <= '0;
    time_now_i     <= '0;
    begin_ok_i     <= 1'b0;
    configure_ok_i <= 1'b0;
    commit_ok_i    <= 1'b0;
    rollback_ok_i  <= 1'b0;
    g_phase     = PH_NEW;
    g_armed     = 1'b1;
    g_rows      = '0;
    g_bytes     = '0;
    g_start     = '0;
    g_row_lim   = ROW_LIM_RST;
    g_byte_lim  = BYTE_LIM_RST;
    g_deadline  = DEADLINE_RST;

    // Oks are {begin, configure, commit, rollback}.
    plan_typed(CMD_OBSERVE, 4'b1111, ST_INVALID, PH_NEW, 1'b1, 1'b0, 1'b0);
    plan_typed(CMD_OPEN, 4'b0000, ST_CLIENT, PH_FAILED, 1'b1, 1'b0, 1'b0);
    plan_typed(CMD_ARM, 4'b0000, ST_OK, PH_NEW, 1'b1, 1'b0, 1'b0);
    plan_typed(CMD_OPEN, 4'b1000, ST_RB_ERR, PH_FAILED, 1'b1, 1'b0, 1'b1);
    plan_typed(CMD_ARM, 4'b1111, ST_OK, PH_NEW, 1'b1, 1'b0, 1'b0);
    plan_word(CMD_OPEN, 32'd0, 48'd1000, 4'b1111);
    plan_word(CMD_OBSERVE, 32'hFFFF_FFFF, 48'd1000, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd0, 48'd31000, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd1, 48'd31001, 4'b1111);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b0000);
    plan_word(CMD_OPEN, 32'd0, 48'hFFFF_FFFF_FFFF, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd7, 48'd0, 4'b1110);
    plan_limits(32'd1, BYTE_LIM_RST, 32'd1);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b1111);
    plan_word(CMD_OPEN, 32'd0, 48'd5, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd0, 48'd6, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd0, 48'd6, 4'b1111);
    plan_limits(ROW_LIM_RST, 48'd1, 32'hFFFF_FFFF);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b1111);
    plan_typed(CMD_OPEN, 4'b1001, ST_CLIENT, PH_ROLLED, 1'b1, 1'b0, 1'b1);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b1111);
    plan_word(CMD_OPEN, 32'd0, 48'd0, 4'b1111);
    plan_word(CMD_OBSERVE, 32'd2, 48'd0, 4'b1111);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b1111);
    plan_word(CMD_OPEN, 32'd0, 48'd0, 4'b1111);
    plan_typed(CMD_FAIL, 4'b1111, ST_CLIENT, PH_ROLLED, 1'b1, 1'b0, 1'b1);
    plan_typed(CMD_FINISH, 4'b1111, ST_INVALID, PH_ROLLED, 1'b1, 1'b0, 1'b0);
    plan_word(CMD_ARM, 32'd0, 48'd0, 4'b1111);
    plan_word(CMD_OPEN, 32'd0, 48'd0, 4'b1111);
    plan_typed(CMD_CLEANUP, 4'b1110, ST_RB_ERR, PH_FAILED, 1'b0, 1'b0, 1'b1);
    plan_typed(CMD_CLEANUP, 4'b1111, ST_OK, PH_FAILED, 1'b0, 1'b0, 1'b0);
    plan_typed(CMD_SPARE_LO, 4'b1111, ST_INVALID, PH_FAILED, 1'b0, 1'b0, 1'b0);
    plan_typed(CMD_SPARE_HI, 4'b1111, ST_INVALID, PH_FAILED, 1'b0, 1'b0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_guard();
        program_limits(plan[i].lim_rows, plan[i].lim_bytes, plan[i].lim_deadline);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].res);
      end
    end

    random_base = words_sent;
    phase_no = 0;
    while (words_sent - random_base < RANDOM_WORDS) begin
      settle_guard();
      if (phase_no == 0) begin
        lim_r = ROW_LIM_RST;
        lim_b = BYTE_LIM_RST;
        lim_d = DEADLINE_RST;
      end else if (phase_no == 1) begin
        lim_r = 32'd1;
        lim_b = 48'd1;
        lim_d = 32'd1;
      end else begin
        case ($urandom_range(0, 2))
          0: lim_r = 32'($urandom_range(1, 8));
          1: lim_r = '1;
          default: lim_r = $urandom | 32'd1;
        endcase
        case ($urandom_range(0, 3))
          0: lim_b = 48'($urandom_range(1, 5000));
          1: lim_b = '1;
          2: lim_b = {16'd0, $urandom} | 48'd1;
          default: lim_b = random48() | 48'd1;
        endcase
        case ($urandom_range(0, 2))
          0: lim_d = 32'($urandom_range(1, 200));
          1: lim_d = '1;
          default: lim_d = $urandom | 32'd1;
        endcase
      end
      program_limits(lim_r, lim_b, lim_d);
      src_idle_max  = (phase_no % 2 == 1) ? IDLE_MAX : 0;
      sink_idle_max = (phase_no % 4 >= 2) ? IDLE_MAX : 0;
      phase_base = words_sent;
      while (words_sent - phase_base < PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(make_word(3'($urandom_range(0, 7)), random48()), 1'b0, '0);
        end else begin
          t0 = ($urandom_range(0, 7) == 0) ? 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 50))
                                            : random48();
          if ($urandom_range(0, 7) != 0) send_word(make_word(CMD_ARM, t0), 1'b0, '0);
          w = make_word(CMD_OPEN, t0);
          w.begin_ok     = ($urandom_range(0, 9) != 0);
          w.configure_ok = ($urandom_range(0, 9) != 0);
          send_word(w, 1'b0, '0);
          t = t0;
          repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 15))
              0: t = t0 - TIME_W'(1);
              1: t = random48();
              2: t = t0 + TIME_W'(g_deadline);
              3: t = t0 + TIME_W'(g_deadline) + TIME_W'(1);
              default: t = t + TIME_W'($urandom_range(0, (g_deadline < 4000) ?
                                                            g_deadline / 2 + 1 : 2000));
            endcase
            w = make_word(CMD_OBSERVE, t);
            case ($urandom_range(0, 4))
              0: w.row_size = 32'($urandom_range(0, 16));
              1: w.row_size = 32'($urandom_range(0, 2000));
              2: w.row_size = $urandom;
              3: w.row_size = 32'hFFFF_FFFF;
              default: w.row_size = 32'($urandom_range(1, 64));
            endcase
            send_word(w, 1'b0, '0);
          end
          case ($urandom_range(0, 4))
            0: send_word(make_word(CMD_FINISH, t), 1'b0, '0);
            1: send_word(make_word(CMD_FAIL, t), 1'b0, '0);
            2: send_word(make_word(CMD_CLEANUP, t), 1'b0, '0);
            default: ;
          endcase
          if ($urandom_range(0, 3) == 0)
            send_word(make_word(3'($urandom_range(0, 4)), t), 1'b0, '0);
        end
      end
      phase_no++;
    end

    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("transaction_quota_guard: match");
    end else begin
      $display("transaction_quota_guard: mismatch");
    end
    $finish;
  end

endmodule
